FILE: src/mte_pkg.sv
// shared types, constants and code tables of the morse text encoder
package mte_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned DurW  = 21;
  localparam int unsigned SegUW = 5;

  localparam logic [2:0] CMD_CHAR = 3'd0;
  localparam logic [2:0] CMD_EOT  = 3'd1;
  localparam logic [2:0] CMD_SOM  = 3'd2;
  localparam logic [2:0] CMD_EOM  = 3'd3;
  localparam logic [2:0] CMD_ERR  = 3'd4;
  localparam logic [2:0] CMD_UND  = 3'd5;
  localparam logic [2:0] CMD_WAIT = 3'd6;
  localparam logic [2:0] CMD_CTS  = 3'd7;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PERIOD = 8'h2e;

  localparam logic [SegUW-1:0] U_DOT   = 5'd1;
  localparam logic [SegUW-1:0] U_DASH  = 5'd3;
  localparam logic [SegUW-1:0] U_SPACE = 5'd1;
  localparam logic [SegUW-1:0] U_EOS   = 5'd2;
  localparam logic [SegUW-1:0] U_WORD  = 5'd6;
  localparam logic [SegUW-1:0] U_SENT  = 5'd10;
  localparam logic [SegUW-1:0] U_EOM   = 5'd21;
  localparam logic [SegUW-1:0] U_NONE  = 5'd0;

  localparam logic [UnitW-1:0] UNIT_RESET = 16'd60;

  typedef enum logic [2:0] {
    SEG_GAP,
    SEG_ON,
    SEG_OFF,
    SEG_EOS,
    SEG_TRAIL
  } seg_e;

  // pattern is sent msb first from bit top, 1 is a dash
  typedef struct packed {
    logic       ok;
    logic [2:0] top;
    logic [7:0] pat;
  } code_t;

  typedef struct packed {
    logic load;
    logic emit;
    seg_e kind;
    logic last;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic nx_gap;
    logic nx_code;
    logic nx_trail;
    logic code;
    logic trail;
    logic elem_zero;
    logic out_free;
  } sts_t;

  function automatic code_t mk(input logic [3:0] len, input logic [7:0] pat);
    code_t c;
    c.ok  = 1'b1;
    c.top = 3'(len - 4'd1);
    c.pat = pat;
    return c;
  endfunction

  function automatic code_t char_code(input logic [7:0] ch);
    logic [7:0] up;
    code_t      c;
    up = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'h20 : ch;
    c  = '0;
    unique case (up)
      8'h41: c = mk(4'd2, 8'b01);
      8'h42: c = mk(4'd4, 8'b1000);
      8'h43: c = mk(4'd4, 8'b1010);
      8'h44: c = mk(4'd3, 8'b100);
      8'h45: c = mk(4'd1, 8'b0);
      8'h46: c = mk(4'd4, 8'b0010);
      8'h47: c = mk(4'd3, 8'b110);
      8'h48: c = mk(4'd4, 8'b0000);
      8'h49: c = mk(4'd2, 8'b00);
      8'h4a: c = mk(4'd4, 8'b0111);
      8'h4b: c = mk(4'd3, 8'b101);
      8'h4c: c = mk(4'd4, 8'b0100);
      8'h4d: c = mk(4'd2, 8'b11);
      8'h4e: c = mk(4'd2, 8'b10);
      8'h4f: c = mk(4'd3, 8'b111);
      8'h50: c = mk(4'd4, 8'b0110);
      8'h51: c = mk(4'd4, 8'b1101);
      8'h52: c = mk(4'd3, 8'b010);
      8'h53: c = mk(4'd3, 8'b000);
      8'h54: c = mk(4'd1, 8'b1);
      8'h55: c = mk(4'd3, 8'b001);
      8'h56: c = mk(4'd4, 8'b0001);
      8'h57: c = mk(4'd3, 8'b011);
      8'h58: c = mk(4'd4, 8'b1001);
      8'h59: c = mk(4'd4, 8'b1011);
      8'h5a: c = mk(4'd4, 8'b1100);
      8'h30: c = mk(4'd5, 8'b11111);
      8'h31: c = mk(4'd5, 8'b01111);
      8'h32: c = mk(4'd5, 8'b00111);
      8'h33: c = mk(4'd5, 8'b00011);
      8'h34: c = mk(4'd5, 8'b00001);
      8'h35: c = mk(4'd5, 8'b00000);
      8'h36: c = mk(4'd5, 8'b10000);
      8'h37: c = mk(4'd5, 8'b11000);
      8'h38: c = mk(4'd5, 8'b11100);
      8'h39: c = mk(4'd5, 8'b11110);
      8'h2e: c = mk(4'd6, 8'b010101);
      8'h2c: c = mk(4'd6, 8'b110011);
      8'h3a: c = mk(4'd6, 8'b111000);
      8'h3f: c = mk(4'd6, 8'b001100);
      8'h27: c = mk(4'd6, 8'b011110);
      8'h2d: c = mk(4'd6, 8'b100001);
      8'h2f: c = mk(4'd5, 8'b10010);
      8'h28: c = mk(4'd5, 8'b10110);
      8'h29: c = mk(4'd6, 8'b101101);
      8'h22: c = mk(4'd6, 8'b010010);
      8'h3d: c = mk(4'd5, 8'b10001);
      8'h2b: c = mk(4'd5, 8'b01010);
      8'h2a: c = mk(4'd4, 8'b1001);
      8'h40: c = mk(4'd6, 8'b011010);
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic code_t prosign_code(input logic [2:0] cmd);
    code_t c;
    c = '0;
    unique case (cmd)
      CMD_SOM:  c = mk(4'd5, 8'b10101);
      CMD_EOM:  c = mk(4'd6, 8'b000101);
      CMD_ERR:  c = mk(4'd8, 8'b00000000);
      CMD_UND:  c = mk(4'd5, 8'b00010);
      CMD_WAIT: c = mk(4'd5, 8'b01000);
      CMD_CTS:  c = mk(4'd3, 8'b101);
      default:  c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: src/mte_datapath.sv
// datapath: item plan, element counter, sentence state, unit register and output register
module mte_datapath import mte_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [UnitW-1:0] cfg_wdata_i,
  input  logic [2:0]       command_i,
  input  logic [7:0]       char_code_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic             key_on_o,
  output logic [DurW-1:0]  duration_o,
  output logic             last_o
);

  logic [UnitW-1:0] unit_q;
  logic             sent_open_q, sent_open_d;
  logic             space_pend_q, space_pend_d;
  logic             code_q;
  logic [7:0]       pat_q;
  logic [2:0]       elem_q;
  logic [SegUW-1:0] trail_q;
  logic             out_valid_q;
  logic             key_q;
  logic [DurW-1:0]  dur_q;
  logic             last_q;

  code_t            nx_code;
  logic             nx_gap;
  logic [SegUW-1:0] nx_trail;
  logic [SegUW-1:0] seg_units;
  logic             seg_key;
  logic [DurW-1:0]  seg_dur;

  // plan of the item at the input
  always_comb begin
    nx_code      = '0;
    nx_gap       = 1'b0;
    nx_trail     = U_NONE;
    sent_open_d  = sent_open_q;
    space_pend_d = space_pend_q;
    if (command_i == CMD_CHAR) begin
      if (char_code_i == CH_NUL) begin
        nx_code = '0;
      end else if (char_code_i == CH_SPACE) begin
        space_pend_d = 1'b1;
      end else begin
        nx_code      = char_code(char_code_i);
        nx_gap       = space_pend_q && sent_open_q;
        space_pend_d = 1'b0;
        if (nx_code.ok) begin
          if (char_code_i == CH_PERIOD) begin
            nx_trail    = U_SENT;
            sent_open_d = 1'b0;
          end else begin
            sent_open_d = 1'b1;
          end
        end
      end
    end else if (command_i == CMD_EOT) begin
      nx_trail     = sent_open_q ? U_SENT : U_NONE;
      sent_open_d  = 1'b0;
      space_pend_d = 1'b0;
    end else begin
      nx_code  = prosign_code(command_i);
      nx_trail = (command_i == CMD_EOM) ? U_EOM : U_SENT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q       <= UNIT_RESET;
      sent_open_q  <= 1'b0;
      space_pend_q <= 1'b0;
      code_q       <= 1'b0;
      trail_q      <= U_NONE;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unit_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        sent_open_q  <= sent_open_d;
        space_pend_q <= space_pend_d;
        code_q       <= nx_code.ok;
        trail_q      <= nx_trail;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pat_q  <= nx_code.pat;
      elem_q <= nx_code.top;
    end else if (cmd_i.step) begin
      elem_q <= elem_q - 3'd1;
    end
    if (cmd_i.emit) begin
      key_q  <= seg_key;
      dur_q  <= seg_dur;
      last_q <= cmd_i.last;
    end
  end

  always_comb begin
    seg_key   = 1'b0;
    seg_units = U_NONE;
    unique case (cmd_i.kind)
      SEG_GAP:   seg_units = U_WORD;
      SEG_ON: begin
        seg_key   = 1'b1;
        seg_units = pat_q[elem_q] ? U_DASH : U_DOT;
      end
      SEG_OFF:   seg_units = U_SPACE;
      SEG_EOS:   seg_units = U_EOS;
      SEG_TRAIL: seg_units = trail_q;
      default:   seg_units = U_NONE;
    endcase
  end

  assign seg_dur = DurW'(seg_units) * DurW'(unit_q);

  assign sts_o.nx_gap    = nx_gap;
  assign sts_o.nx_code   = nx_code.ok;
  assign sts_o.nx_trail  = (nx_trail != U_NONE);
  assign sts_o.code      = code_q;
  assign sts_o.trail     = (trail_q != U_NONE);
  assign sts_o.elem_zero = (elem_q == 3'd0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign key_on_o    = key_q;
  assign duration_o  = dur_q;
  assign last_o      = last_q;

endmodule

FILE: src/mte_ctrl.sv
// controller: steps through word gap, code elements, end of symbol and trailing gap
module mte_ctrl import mte_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GAP   = 3'd1;
  localparam logic [2:0] S_ON    = 3'd2;
  localparam logic [2:0] S_OFF   = 3'd3;
  localparam logic [2:0] S_EOS   = 3'd4;
  localparam logic [2:0] S_TRAIL = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.kind   = SEG_GAP;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          priority if (sts_i.nx_gap) state_d = S_GAP;
          else if (sts_i.nx_code)    state_d = S_ON;
          else if (sts_i.nx_trail)   state_d = S_TRAIL;
          else                       state_d = S_IDLE;
        end
      end
      S_GAP: begin
        cmd_o.kind = SEG_GAP;
        cmd_o.last = !sts_i.code && !sts_i.trail;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          priority if (sts_i.code) state_d = S_ON;
          else if (sts_i.trail)    state_d = S_TRAIL;
          else                     state_d = S_IDLE;
        end
      end
      S_ON: begin
        cmd_o.kind = SEG_ON;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_OFF;
        end
      end
      S_OFF: begin
        cmd_o.kind = SEG_OFF;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.step = !sts_i.elem_zero;
          state_d    = sts_i.elem_zero ? S_EOS : S_ON;
        end
      end
      S_EOS: begin
        cmd_o.kind = SEG_EOS;
        cmd_o.last = !sts_i.trail;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.trail ? S_TRAIL : S_IDLE;
        end
      end
      S_TRAIL: begin
        cmd_o.kind = SEG_TRAIL;
        cmd_o.last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free) else $error("segment written into a full output register");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.last |=> state_q == S_IDLE) else $error("work left after last segment");

  a_hold_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE && !sts_i.out_free |=> $stable(state_q))
    else $error("controller advanced while output was blocked");

  a_step_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> state_q == S_OFF && cmd_o.emit) else $error("element step outside a space");

endmodule

FILE: src/morse_text_encoder.sv
// top level of the morse text encoder: controller plus datapath
// Each accepted item (a character or a command) yields up to eighteen keying segments,
// one per clock cycle while the output is not stalled, from a controller that walks word
// gap, code elements, end of symbol and trailing gap; an item keeps the input stalled after
// its transfer until its last segment is written, and one that yields none does not stall
// the input. The last segment of an item may wait in the output register while the next
// item is taken. Durations are the unit count times the unit register, formed in one 21-bit
// multiply ahead of the output register.
module morse_text_encoder import mte_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [UnitW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       command_i,
  input  logic [7:0]       char_code_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             key_on_o,
  output logic [DurW-1:0]  duration_o,
  output logic             last_o
);

  cmd_t cmd;
  sts_t sts;

  mte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mte_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .command_i   (command_i),
    .char_code_i (char_code_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .key_on_o    (key_on_o),
    .duration_o  (duration_o),
    .last_o      (last_o)
  );

endmodule

FILE: sim/morse_text_encoder_tb.sv
// self-checking testbench for the morse text encoder with a keying segment scoreboard
module morse_text_encoder_tb;
  import mte_pkg::*;

  localparam int DOT_U      = 1;
  localparam int DASH_U     = 3;
  localparam int ELEM_GAP_U = 1;
  localparam int SYM_END_U  = 2;
  localparam int WORD_GAP_U = 6;
  localparam int SENT_GAP_U = 10;
  localparam int EOM_GAP_U  = 21;

  localparam int SETTLE_CYCLES = 4;
  localparam int STUCK_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 39;

  typedef struct packed {
    logic            key_on;
    logic [DurW-1:0] duration;
    logic            last;
  } seg_t;

  class keying_scoreboard;
    seg_t             awaited[$];
    seg_t             fresh[$];
    logic [UnitW-1:0] unit;
    bit               sentence_open;
    bit               space_pending;
    int               errors;
    int               n_inputs;
    int               n_segments;
    string            letter_pat[26];
    string            punct_chars;
    string            punct_pat[14];

    function new();
      letter_pat = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                     ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                     "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
      punct_chars = ".,:?'-/()\"=+*@";
      punct_pat = '{".-.-.-", "--..--", "---...", "..--..", ".----.", "-....-", "-..-.",
                    "-.--.", "-.--.-", ".-..-.", "-...-", ".-.-.", "-..-", ".--.-."};
      unit = 16'd60;
    endfunction

    function string char_pattern(logic [7:0] ch);
      string s;
      int    d;
      s = "";
      if (ch >= 8'h30 && ch <= 8'h39) begin
        d = ch - 8'h30;
        for (int i = 0; i < 5; i++) begin
          if (d <= 5) begin
            if (i < d) s = {s, "."};
            else s = {s, "-"};
          end else begin
            if (i < d - 5) s = {s, "-"};
            else s = {s, "."};
          end
        end
      end else if (ch >= 8'h41 && ch <= 8'h5a) begin
        s = letter_pat[ch - 8'h41];
      end else if (ch >= 8'h61 && ch <= 8'h7a) begin
        s = letter_pat[ch - 8'h61];
      end else begin
        for (int i = 0; i < punct_chars.len(); i++)
          if (punct_chars[i] == ch) s = punct_pat[i];
      end
      return s;
    endfunction

    function string prosign_pattern(logic [2:0] cmd);
      case (cmd)
        CMD_SOM:  return "-.-.-";
        CMD_EOM:  return "...-.-";
        CMD_ERR:  return "........";
        CMD_UND:  return "...-.";
        CMD_WAIT: return ".-...";
        CMD_CTS:  return "-.-";
        default:  return "";
      endcase
    endfunction

    function void add_seg(bit key, int units);
      seg_t s;
      s.key_on   = key;
      s.duration = DurW'(units * unit);
      s.last     = 1'b0;
      fresh.push_back(s);
    endfunction

    function void add_code(string pat);
      for (int i = 0; i < pat.len(); i++) begin
        add_seg(1'b1, (pat[i] == "-") ? DASH_U : DOT_U);
        add_seg(1'b0, ELEM_GAP_U);
      end
      add_seg(1'b0, SYM_END_U);
    endfunction

    function void note_input(logic [2:0] cmd, logic [7:0] ch);
      string pat;
      fresh.delete();
      n_inputs++;
      if (cmd == CMD_CHAR) begin
        if (ch == CH_NUL) begin
          // ignored altogether
        end else if (ch == CH_SPACE) begin
          space_pending = 1'b1;
        end else begin
          pat = char_pattern(ch);
          if (space_pending) begin
            space_pending = 1'b0;
            if (sentence_open) add_seg(1'b0, WORD_GAP_U);
          end
          if (pat.len() > 0) begin
            add_code(pat);
            if (ch == CH_PERIOD) begin
              add_seg(1'b0, SENT_GAP_U);
              sentence_open = 1'b0;
            end else begin
              sentence_open = 1'b1;
            end
          end
        end
      end else if (cmd == CMD_EOT) begin
        if (sentence_open) add_seg(1'b0, SENT_GAP_U);
        sentence_open = 1'b0;
        space_pending = 1'b0;
      end else begin
        add_code(prosign_pattern(cmd));
        add_seg(1'b0, (cmd == CMD_EOM) ? EOM_GAP_U : SENT_GAP_U);
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) awaited.push_back(fresh[i]);
    endfunction

    function void check_segment(logic key_on, logic [DurW-1:0] duration, logic last);
      seg_t want;
      n_segments++;
      if (awaited.size() == 0) begin
        errors++;
        $error("unexpected segment: key_on %0d duration %0d last %0d", key_on, duration, last);
        return;
      end
      want = awaited.pop_front();
      if (key_on !== want.key_on) begin
        errors++;
        $error("key_on: expected %0d, got %0d", want.key_on, key_on);
      end
      if (duration !== want.duration) begin
        errors++;
        $error("duration: expected %0d, got %0d", want.duration, duration);
      end
      if (last !== want.last) begin
        errors++;
        $error("last: expected %0d, got %0d", want.last, last);
      end
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [UnitW-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [2:0]       command_i   = CMD_CHAR;
  logic [7:0]       char_code_i = CH_NUL;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             key_on_o;
  logic [DurW-1:0]  duration_o;
  logic             last_o;

  keying_scoreboard sb;
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               stuck_cycles   = 0;

  string text_pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.,:?'-/()\"=+*@";

  logic [10:0] opening_text[] = '{
    {CMD_CHAR, 8'h45}, {CMD_CHAR, CH_SPACE}, {CMD_CHAR, 8'h61}, {CMD_CHAR, CH_SPACE},
    {CMD_CHAR, CH_SPACE}, {CMD_CHAR, 8'h80}, {CMD_CHAR, 8'h30}, {CMD_CHAR, 8'h39},
    {CMD_CHAR, CH_PERIOD}, {CMD_CHAR, CH_SPACE}, {CMD_CHAR, 8'h54}, {CMD_CHAR, CH_NUL},
    {CMD_CHAR, 8'hff}, {CMD_CHAR, 8'h7a}, {CMD_CHAR, CH_SPACE}, {CMD_EOT, CH_PERIOD},
    {CMD_EOT, CH_NUL}, {CMD_SOM, 8'h41}, {CMD_EOM, CH_NUL}, {CMD_ERR, 8'h55},
    {CMD_UND, 8'haa}, {CMD_WAIT, CH_SPACE}, {CMD_CTS, 8'hff}, {CMD_CHAR, 8'h40},
    {CMD_CHAR, 8'h2c}
  };

  logic [UnitW-1:0] phase_unit[4];
  int               phase_idle[4]  = '{0, 54, 0, 17};
  int               phase_stall[4] = '{0, 0, 54, 17};

  morse_text_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .char_code_i (char_code_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .key_on_o    (key_on_o),
    .duration_o  (duration_o),
    .last_o      (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_segment(key_on_o, duration_o, last_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("no transfer for %0d cycles", STUCK_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [2:0] cmd, input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    char_code_i <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(cmd, ch);
    @(negedge clk_i);
  endtask

  task automatic drain_phase();
    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_unit(input logic [UnitW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.unit = value;
  endtask

  // mostly running text, with stray bytes, end of text and prosigns mixed in
  function automatic void pick_item(output logic [2:0] cmd, output logic [7:0] ch);
    int r;
    r   = $urandom_range(99);
    cmd = CMD_CHAR;
    ch  = 8'($urandom_range(255));
    if (r < 55) ch = text_pool[$urandom_range(text_pool.len() - 1)];
    else if (r < 70) ch = CH_SPACE;
    else if (r < 78) ch = CH_PERIOD;
    else if (r < 86) cmd = CMD_CHAR;
    else if (r < 93) cmd = CMD_EOT;
    else cmd = 3'($urandom_range(7, 2));
  endfunction

  initial begin
    logic [2:0] cmd;
    logic [7:0] ch;
    int         sent;
    sb = new();
    phase_unit[0] = 16'hffff;
    phase_unit[1] = 16'd1;
    phase_unit[2] = 16'd0;
    phase_unit[3] = 16'($urandom_range(65534, 2));
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (opening_text[i]) send_item(opening_text[i][10:8], opening_text[i][7:0]);
    drain_phase();

    for (int p = 0; p < 4; p++) begin
      write_unit(phase_unit[p]);
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick_item(cmd, ch);
        send_item(cmd, ch);
        if (!(cmd == CMD_CHAR && ch == CH_NUL)) sent++;
      end
      drain_phase();
      recv_stall_pct = 0;
    end

    if (sb.awaited.size() != 0) begin
      sb.errors++;
      $error("%0d segments never arrived", sb.awaited.size());
    end
    $display("covered %0d input transfers and %0d keying segments", sb.n_inputs,
             sb.n_segments);
    $display("unit lengths 60, 65535, 1, 0 and %0d under four idling and stall mixes",
             phase_unit[3]);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/mte_pkg.sv
src/mte_datapath.sv
src/mte_ctrl.sv
src/morse_text_encoder.sv
sim/morse_text_encoder_tb.sv
